>>> design/stip_pkg.sv
// Shared types, constants and character codes of the ASCII integer parser.
package stip_pkg;

  localparam int COUNT_MAX  = 255;
  localparam int COUNT_W    = $clog2(COUNT_MAX + 1);
  localparam int CHARS_MAX  = 255;
  localparam int VALUE_W    = 64;
  localparam int CHARS_W    = 8;
  localparam int BASE_W     = 5;
  localparam int CHAR_W     = 8;

  localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

  localparam logic [CHAR_W-1:0] HEX_ALPHA_OFS = 8'd10;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } digit_t;

  typedef struct packed {
    logic                emit;
    logic [VALUE_W-1:0]  value;
    logic [CHARS_W-1:0]  chars;
    logic [BASE_W-1:0]   base;
  } step_res_t;

endpackage

>>> design/stip_digit.sv
// Digit decoder: value of one ASCII character in base 8, 10 or 16.
module stip_digit (
  input  logic [stip_pkg::CHAR_W-1:0] ch,
  input  logic [stip_pkg::BASE_W-1:0] base,
  output stip_pkg::digit_t            digit
);
  import stip_pkg::*;

  logic is_dec;
  logic is_oct;
  logic is_lo;
  logic is_up;
  logic [CHAR_W-1:0] dec_val;
  logic [CHAR_W-1:0] lo_val;
  logic [CHAR_W-1:0] up_val;

  assign is_dec  = (ch >= CH_0) && (ch <= CH_9);
  assign is_oct  = (ch >= CH_0) && (ch <= CH_7);
  assign is_lo   = (ch >= CH_LO_A) && (ch <= CH_LO_F);
  assign is_up   = (ch >= CH_UP_A) && (ch <= CH_UP_F);
  assign dec_val = ch - CH_0;
  assign lo_val  = ch - CH_LO_A + HEX_ALPHA_OFS;
  assign up_val  = ch - CH_UP_A + HEX_ALPHA_OFS;

  always_comb begin
    digit.ok    = 1'b0;
    digit.value = dec_val[3:0];
    case (base)
      BASE_HEX: begin
        if (is_lo) begin
          digit.ok    = 1'b1;
          digit.value = lo_val[3:0];
        end else if (is_up) begin
          digit.ok    = 1'b1;
          digit.value = up_val[3:0];
        end else begin
          digit.ok    = is_dec;
        end
      end
      BASE_DEC: digit.ok = is_dec;
      BASE_OCT: digit.ok = is_oct;
      default:  digit.ok = 1'b0;
    endcase
  end

endmodule

>>> design/stip_step.sv
// Parse state and the per-character update: prefix detection, digit accumulate, result.
module stip_step (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [stip_pkg::CHAR_W-1:0] ch,
  input  logic                        start,
  input  logic [stip_pkg::BASE_W-1:0] number_base,
  output stip_pkg::step_res_t         res
);
  import stip_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [VALUE_W-1:0]   acc_r, acc_nxt;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BASE_W-1:0]    base_r, base_nxt;

  logic                 is_x;
  logic                 base_ok;
  logic                 do_take;
  logic                 bad_base;
  logic                 zero_lead;
  logic                 x_prefix;
  logic [BASE_W-1:0]    tk_base;
  logic [VALUE_W-1:0]   tk_acc;
  logic [COUNT_W-1:0]   tk_cnt;
  logic [COUNT_W-1:0]   tk_cnt_inc;
  logic [COUNT_W-1:0]   cnt_inc;
  logic [VALUE_W-1:0]   acc_scaled;
  logic [VALUE_W-1:0]   acc_new;
  digit_t               digit;

  assign is_x    = (ch == CH_LO_X) || (ch == CH_UP_X);
  assign base_ok = (number_base == BASE_OCT) || (number_base == BASE_DEC) ||
                   (number_base == BASE_HEX);

  // Which path this character takes and the operands of the digit step
  always_comb begin
    do_take   = 1'b0;
    bad_base  = 1'b0;
    zero_lead = 1'b0;
    x_prefix  = 1'b0;
    tk_base   = base_r;
    tk_acc    = acc_r;
    tk_cnt    = cnt_r;
    if (start) begin
      tk_acc = '0;
      tk_cnt = '0;
      if (number_base == BASE_AUTO) begin
        if (ch == CH_0) begin
          zero_lead = 1'b1;
        end else begin
          do_take = 1'b1;
          tk_base = BASE_DEC;
        end
      end else if (base_ok) begin
        do_take = 1'b1;
        tk_base = number_base;
      end else begin
        bad_base = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_ZERO: begin
          if (is_x) begin
            x_prefix = 1'b1;
          end else begin
            do_take = 1'b1;
            tk_base = BASE_OCT;
          end
        end
        PH_DIGITS: do_take = 1'b1;
        default:   do_take = 1'b0;
      endcase
    end
  end

  stip_digit u_digit (
    .ch    (ch),
    .base  (tk_base),
    .digit (digit)
  );

  always_comb begin
    case (tk_base)
      BASE_HEX: acc_scaled = tk_acc << 4;
      BASE_DEC: acc_scaled = (tk_acc << 3) + (tk_acc << 1);
      default:  acc_scaled = tk_acc << 3;
    endcase
  end

  assign acc_new    = acc_scaled + {{(VALUE_W-4){1'b0}}, digit.value};
  assign tk_cnt_inc = (tk_cnt == COUNT_W'(COUNT_MAX)) ? tk_cnt : tk_cnt + 1'b1;
  assign cnt_inc    = (cnt_r == COUNT_W'(COUNT_MAX)) ? cnt_r : cnt_r + 1'b1;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step_en) begin
      if (zero_lead) begin
        phase_nxt = PH_ZERO;
      end else if (x_prefix) begin
        phase_nxt = PH_DIGITS;
      end else if (bad_base) begin
        phase_nxt = PH_IDLE;
      end else if (do_take) begin
        phase_nxt = digit.ok ? PH_DIGITS : PH_IDLE;
      end
    end
  end

  // Datapath state and result
  always_comb begin
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    base_nxt   = base_r;
    res.emit   = 1'b0;
    res.value  = tk_acc;
    res.chars  = ({{(32-COUNT_W){1'b0}}, tk_cnt} > 32'(CHARS_MAX)) ?
                 CHARS_W'(CHARS_MAX) : CHARS_W'(tk_cnt);
    res.base   = tk_base;
    if (zero_lead) begin
      acc_nxt  = '0;
      cnt_nxt  = COUNT_W'(1);
      base_nxt = BASE_AUTO;
    end else if (x_prefix) begin
      cnt_nxt  = cnt_inc;
      base_nxt = BASE_HEX;
    end else if (bad_base) begin
      res.emit  = 1'b1;
      res.value = '0;
      res.chars = '0;
      res.base  = BASE_AUTO;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      base_nxt  = BASE_AUTO;
    end else if (do_take) begin
      base_nxt = tk_base;
      if (digit.ok) begin
        acc_nxt = acc_new;
        cnt_nxt = tk_cnt_inc;
      end else begin
        res.emit = 1'b1;
        acc_nxt  = tk_acc;
        cnt_nxt  = tk_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      cnt_r   <= '0;
      base_r  <= BASE_AUTO;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      base_r  <= base_nxt;
    end
  end

endmodule

>>> design/string_to_integer_parser_core.sv
// Top level of the ASCII integer parser: input register, parse step, result register, APB.
//
// Input stream: one character per beat on in_tdata, in_tuser high on the
// first character of a string. Each string yields at most one result beat:
// value, characters consumed and base used, sent when the first character
// that is not a digit of the base arrives, or at once on the start character
// if number_base is invalid. Later characters are dropped until the next start.
// A character accepted lands in the input register and is applied to the parse
// state when it advances; a result it yields is registered in the output register.
// Throughput: one character per cycle while no result beat is stalled; the digit
// step (shift-add by the base plus the digit) is combinational against the parse state.
// When the receiver stalls the result holds in the output register and the
// input register still takes one more character; after that in_tready drops
// until the result beat goes.
// Reset (rst_n low, synchronous) empties both registers, returns the parse to
// idle and sets number_base (APB byte address 0) to 0, auto-detect.
// A change of number_base takes effect at the next string start.
module string_to_integer_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] character
  input  logic [7:0]  in_tdata,
  // in_tuser: [0] start_req
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [63:0] parsed_value, [71:64] chars_consumed, [76:72] base_used,
  // [79:77] zero
  output logic [79:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import stip_pkg::*;

  logic                s1_valid_r, s1_valid_nxt;
  logic [CHAR_W-1:0]   s1_char_r;
  logic                s1_start_r;
  logic                advance;
  logic                in_beat;
  logic                out_valid_r, out_valid_nxt;
  logic [79:0]         out_data_r;
  logic [BASE_W-1:0]   number_base_r;
  logic                cfg_wr;
  step_res_t           res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {{(32-BASE_W){1'b0}}, number_base_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= BASE_AUTO;
    end else if (cfg_wr) begin
      number_base_r <= cfg_pwdata[BASE_W-1:0];
    end
  end

  assign advance      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready    = !s1_valid_r || advance;
  assign in_beat      = in_tvalid && in_tready;
  assign s1_valid_nxt = in_beat || (s1_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_char_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  stip_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .ch          (s1_char_r),
    .start       (s1_start_r),
    .number_base (number_base_r),
    .res         (res)
  );

  assign out_valid_nxt = advance ? res.emit : (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_data_r <= {3'b000, res.base, res.chars, res.value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
